FILE: design/rmze_pkg.sv
`timescale 1ns / 1ps
package rmze_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int ANG_BITS         = 30;
  localparam int OUT_SHIFT        = ANG_BITS - FRAC_BITS;
  localparam int IN_W             = 18;
  localparam int EXT_W            = IN_W + 1;
  localparam int OUT_W            = 19;
  localparam int LIM_W            = 17;
  localparam int ZW               = 35;
  localparam int XW               = 33;
  localparam int GUARD_SHIFT      = 12;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int ROOT_STAGES      = 17;
  localparam int ARG_W            = 33;
  localparam int ROOT_W           = 17;
  localparam int MAG_W            = 16;

  localparam logic signed [ZW-1:0] PI_Q      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q  = 35'sd6746518852;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 17'd1;
  localparam logic [2:0]       ADDR_LIMIT  = 3'd0;

  // Outcome of the axis tests at the front of atan2
  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_PI,
    SP_POS_HALF,
    SP_NEG_HALF
  } spec_t;

  typedef struct packed {
    logic signed [EXT_W-1:0] ay;
    logic signed [EXT_W-1:0] ax;
    logic signed [EXT_W-1:0] gy;
    logic signed [EXT_W-1:0] gx;
    logic signed [EXT_W-1:0] m22;
    logic [MAG_W-1:0]        amag;
    logic                    hi;
    logic                    lo;
    logic                    deg;
    logic                    flip;
  } side_t;

  typedef struct packed {
    logic hi;
    logic lo;
    logic deg;
    logic flip;
  } fin_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_q(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 35'sd843314856;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043836;
      5'd3:  v = 35'sd133525158;
      5'd4:  v = 35'sd67021686;
      5'd5:  v = 35'sd33543515;
      5'd6:  v = 35'sd16775850;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194282;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048575;
      5'd11: v = 35'sd524287;
      5'd12: v = 35'sd262143;
      5'd13: v = 35'sd131071;
      5'd14: v = 35'sd65535;
      5'd15: v = 35'sd32767;
      5'd16: v = 35'sd16383;
      5'd17: v = 35'sd8191;
      5'd18: v = 35'sd4095;
      5'd19: v = 35'sd2047;
      5'd20: v = 35'sd1023;
      5'd21: v = 35'sd511;
      5'd22: v = 35'sd255;
      5'd23: v = 35'sd127;
      5'd24: v = 35'sd63;
      5'd25: v = 35'sd31;
      5'd26: v = 35'sd15;
      5'd27: v = 35'sd7;
      5'd28: v = 35'sd3;
      5'd29: v = 35'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/rmze_isqrt.sv
`timescale 1ns / 1ps
module rmze_isqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rmze_pkg::ARG_W-1:0]        arg,
  output logic [rmze_pkg::ROOT_W-1:0]       root
);

  localparam int N = rmze_pkg::ROOT_STAGES;
  localparam int W = rmze_pkg::ARG_W + 1;

  logic [W-1:0] rem_r [N];
  logic [W-1:0] res_r [N];
  logic [W-1:0] rem_in [N];
  logic [W-1:0] res_in [N];

  assign rem_in[0] = W'(arg);
  assign res_in[0] = '0;

  // One result bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
    logic [W-1:0] trial;
    logic         ge;
    if (k > 0) begin : g_link
      assign rem_in[k] = rem_r[k-1];
      assign res_in[k] = res_r[k-1];
    end
    assign trial = res_in[k] + BIT;
    assign ge    = rem_in[k] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_in[k] - trial : rem_in[k];
        res_r[k] <= ge ? (res_in[k] >> 1) + BIT : res_in[k] >> 1;
      end
    end
  end

  assign root = res_r[N-1][rmze_pkg::ROOT_W-1:0];

endmodule

FILE: design/rmze_cordic.sv
`timescale 1ns / 1ps
module rmze_cordic #(
  parameter int STEPS = rmze_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rmze_pkg::EXT_W-1:0]   y_i,
  input  logic signed [rmze_pkg::EXT_W-1:0]   x_i,
  output logic signed [rmze_pkg::ZW-1:0]      z_o
);

  localparam int XW = rmze_pkg::XW;
  localparam int ZW = rmze_pkg::ZW;

  logic signed [XW-1:0] x_r [STEPS+1];
  logic signed [XW-1:0] y_r [STEPS+1];
  logic signed [ZW-1:0] z_r [STEPS+1];
  rmze_pkg::spec_t      sp_r [STEPS+1];
  logic                 yp_r [STEPS+1];

  logic                          xneg, ypos;
  logic signed [rmze_pkg::EXT_W-1:0] xa, ya;
  rmze_pkg::spec_t               sp;
  logic signed [ZW-1:0]          z0;

  // Fold the left half-plane onto the right and note axis cases
  always_comb begin
    xneg = x_i < 0;
    ypos = y_i > 0;
    xa   = xneg ? -x_i : x_i;
    ya   = xneg ? -y_i : y_i;
    z0   = xneg ? (ypos ? rmze_pkg::PI_Q : -rmze_pkg::PI_Q) : '0;
    if (y_i == 0) begin
      sp = xneg ? rmze_pkg::SP_PI : rmze_pkg::SP_ZERO;
    end else if (x_i == 0) begin
      sp = ypos ? rmze_pkg::SP_POS_HALF : rmze_pkg::SP_NEG_HALF;
    end else begin
      sp = rmze_pkg::SP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= XW'(xa) <<< rmze_pkg::GUARD_SHIFT;
      y_r[0]  <= XW'(ya) <<< rmze_pkg::GUARD_SHIFT;
      z_r[0]  <= z0;
      sp_r[0] <= sp;
      yp_r[0] <= ypos;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic d;
    assign d = y_r[i] > 0;
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]  <= d ? x_r[i] + (y_r[i] >>> i) : x_r[i] - (y_r[i] >>> i);
        y_r[i+1]  <= d ? y_r[i] - (x_r[i] >>> i) : y_r[i] + (x_r[i] >>> i);
        z_r[i+1]  <= d ? z_r[i] + rmze_pkg::atan_q(5'(i))
                       : z_r[i] - rmze_pkg::atan_q(5'(i));
        sp_r[i+1] <= sp_r[i];
        yp_r[i+1] <= yp_r[i];
      end
    end
  end

  // Clamp into the half-plane of y, or take the axis value
  always_comb begin
    z_o = z_r[STEPS];
    case (sp_r[STEPS])
      rmze_pkg::SP_ZERO:     z_o = '0;
      rmze_pkg::SP_PI:       z_o = rmze_pkg::PI_Q;
      rmze_pkg::SP_POS_HALF: z_o = rmze_pkg::HALF_PI_Q;
      rmze_pkg::SP_NEG_HALF: z_o = -rmze_pkg::HALF_PI_Q;
      default: begin
        if (yp_r[STEPS]) begin
          if (z_r[STEPS] < 0) z_o = '0;
          else if (z_r[STEPS] > rmze_pkg::PI_Q) z_o = rmze_pkg::PI_Q;
        end else begin
          if (z_r[STEPS] > 0) z_o = '0;
          else if (z_r[STEPS] < -rmze_pkg::PI_Q) z_o = -rmze_pkg::PI_Q;
        end
      end
    endcase
  end

endmodule

FILE: design/rotation_matrix_to_euler_zyz_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------
// in       | in_valid / in_ready          | in_m00..in_m22, 18-bit signed Q2.16
// out      | out_valid / out_ready        | out_alpha, out_gamma (u19), out_beta (s19)
// cfg      | APB write at psel&penable    | near_zero_limit at byte address 0
//
// One matrix enters per cycle while out is not stalled; it passes through the
// square stage, the 17-stage square root and the three parallel CORDIC pipes.
// rst_n is synchronous; it clears valid bits and sets near_zero_limit to 1.
// A stall on out freezes the whole pipeline and drops in_ready; nothing is lost.
module rotation_matrix_to_euler_zyz_unit #(
  parameter int CORDIC_STEPS = rmze_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m00,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m01,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m02,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m12,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m20,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m21,
  input  logic signed [rmze_pkg::IN_W-1:0]     in_m22,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rmze_pkg::OUT_W-1:0]           out_alpha,
  output logic signed [rmze_pkg::OUT_W-1:0]    out_beta,
  output logic [rmze_pkg::OUT_W-1:0]           out_gamma,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [2:0]                           cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int EW   = rmze_pkg::EXT_W;
  localparam int SD_N = rmze_pkg::ROOT_STAGES + 2;  // s0, square, root stages
  localparam int LAT  = SD_N + CORDIC_STEPS + 1;
  localparam int SH   = rmze_pkg::OUT_SHIFT;
  localparam int OW   = rmze_pkg::OUT_W;
  localparam logic signed [EW-1:0] ONE = EW'(1) <<< rmze_pkg::FRAC_BITS;

  logic                       en;
  logic [rmze_pkg::LIM_W-1:0] limit_r;
  logic                       vld_r [LAT];
  rmze_pkg::side_t            sd_r [SD_N];
  rmze_pkg::fin_t             fd_r [CORDIC_STEPS+1];
  rmze_pkg::side_t            side_nxt;
  logic [rmze_pkg::ARG_W-1:0] arg_r;
  logic [rmze_pkg::ROOT_W-1:0] root;
  logic signed [rmze_pkg::ZW-1:0] za, zb, zg;
  logic                       out_valid_r;
  logic [OW-1:0]              alpha_nxt, gamma_nxt, alpha_r, gamma_r;
  logic signed [OW-1:0]       beta_nxt, beta_r;

  // Advance the whole pipe unless a finished result is held back
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rmze_pkg::LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == rmze_pkg::ADDR_LIMIT[2]) begin
      limit_r <= cfg_pwdata[rmze_pkg::LIM_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == rmze_pkg::ADDR_LIMIT[2]) ? 32'(limit_r) : '0;

  // Front decode: pick atan2 operands, clamp tests and the beta sign test
  always_comb begin
    logic signed [EW-1:0] e00, e01, e02, e12, e20, e21, e22, n02;
    logic [EW-1:0]        a02, a12, a20, a21, a22;
    logic                 entry_neg;
    e00 = EW'(in_m00);
    e01 = EW'(in_m01);
    e02 = EW'(in_m02);
    e12 = EW'(in_m12);
    e20 = EW'(in_m20);
    e21 = EW'(in_m21);
    e22 = EW'(in_m22);
    n02 = -e02;
    a02 = e02 < 0 ? -e02 : e02;
    a12 = e12 < 0 ? -e12 : e12;
    a20 = e20 < 0 ? -e20 : e20;
    a21 = e21 < 0 ? -e21 : e21;
    a22 = e22 < 0 ? -e22 : e22;
    side_nxt.hi   = e22 >= ONE;
    side_nxt.lo   = e22 <= -ONE;
    side_nxt.deg  = (a20 < EW'(limit_r)) && (a21 < EW'(limit_r));
    entry_neg     = (a12 > a02) ? (e12 < 0) : (e02 > 0);
    side_nxt.flip = !side_nxt.deg && (side_nxt.hi || side_nxt.lo) && entry_neg;
    side_nxt.ay   = side_nxt.deg ? e01 : e21;
    side_nxt.ax   = side_nxt.deg ? e00 : e20;
    side_nxt.gy   = e12;
    side_nxt.gx   = n02;
    side_nxt.m22  = e22;
    side_nxt.amag = a22[rmze_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // Side data travels with the square root
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_nxt;
      for (int k = 1; k < SD_N; k++) sd_r[k] <= sd_r[k-1];
      arg_r <= (rmze_pkg::ARG_W'(1) << (2 * rmze_pkg::FRAC_BITS)) -
               rmze_pkg::ARG_W'(sd_r[0].amag * sd_r[0].amag);
    end
  end

  rmze_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .arg  (arg_r),
    .root (root)
  );

  rmze_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_alpha (
    .clk (clk), .en (en), .y_i (sd_r[SD_N-1].ay), .x_i (sd_r[SD_N-1].ax), .z_o (za)
  );

  rmze_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_beta (
    .clk (clk), .en (en), .y_i (EW'(root)), .x_i (sd_r[SD_N-1].m22), .z_o (zb)
  );

  rmze_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_gamma (
    .clk (clk), .en (en), .y_i (sd_r[SD_N-1].gy), .x_i (sd_r[SD_N-1].gx), .z_o (zg)
  );

  // Hold the flags alongside the CORDIC pipes
  always_ff @(posedge clk) begin
    if (en) begin
      fd_r[0].hi   <= sd_r[SD_N-1].hi;
      fd_r[0].lo   <= sd_r[SD_N-1].lo;
      fd_r[0].deg  <= sd_r[SD_N-1].deg;
      fd_r[0].flip <= sd_r[SD_N-1].flip;
      for (int k = 1; k <= CORDIC_STEPS; k++) fd_r[k] <= fd_r[k-1];
    end
  end

  // Wrap negative angles by two pi, drop to Q16, apply the beta sign flip
  always_comb begin
    logic signed [rmze_pkg::ZW-1:0] wa, wg, bq;
    logic [OW-1:0]                  bo;
    wa = za < 0 ? za + rmze_pkg::TWO_PI_Q : za;
    wg = zg < 0 ? zg + rmze_pkg::TWO_PI_Q : zg;
    if (fd_r[CORDIC_STEPS].hi)      bq = '0;
    else if (fd_r[CORDIC_STEPS].lo) bq = rmze_pkg::PI_Q;
    else                            bq = zb;
    bo        = bq[SH+OW-1:SH];
    beta_nxt  = fd_r[CORDIC_STEPS].flip ? -bo : bo;
    alpha_nxt = wa[SH+OW-1:SH];
    gamma_nxt = fd_r[CORDIC_STEPS].deg ? '0 : wg[SH+OW-1:SH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
      gamma_r <= gamma_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_alpha = alpha_r;
  assign out_beta  = beta_r;
  assign out_gamma = gamma_r;

endmodule

FILE: design/rmze_checker.sv
`timescale 1ns / 1ps
module rmze_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rmze_pkg::OUT_W-1:0]        out_alpha,
  input logic signed [rmze_pkg::OUT_W-1:0] out_beta,
  input logic [rmze_pkg::OUT_W-1:0]        out_gamma,
  input logic                              cfg_pready
);

  localparam logic [rmze_pkg::OUT_W-1:0] TWO_PI_OUT = 19'd411774;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alpha) && $stable(out_beta)
    && $stable(out_gamma))
    else $error("result dropped or changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha <= TWO_PI_OUT && out_gamma <= TWO_PI_OUT)
    else $error("angle beyond two pi");

  a_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_pready)
    else $error("result valid after reset");

endmodule

bind rotation_matrix_to_euler_zyz_unit rmze_checker u_rmze_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_alpha  (out_alpha),
  .out_beta   (out_beta),
  .out_gamma  (out_gamma),
  .cfg_pready (cfg_pready)
);
